// ===== rtl/core/mdfc_pkg.sv =====
// ----------------------------------------------------------------------------
// mdfc_pkg
// Shared types and constants for the music ducking fade controller.
// ----------------------------------------------------------------------------
package mdfc_pkg;

  localparam int MAX_TRACKS = 4;
  localparam int TRK_W      = $clog2(MAX_TRACKS);
  localparam int COUNT_W    = 3;
  localparam int GAIN_W     = 17;
  localparam int CFG_IDX_W  = 2;

  localparam logic [GAIN_W-1:0] GAIN_UNITY = GAIN_W'(65536);

  // track play states
  localparam logic [1:0] ST_STOPPED = 2'd0;
  localparam logic [1:0] ST_PLAYING = 2'd1;
  localparam logic [1:0] ST_PAUSED  = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_TRACKS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FADE_OUT_STEP = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FADE_IN_STEP  = 2'd2;

  localparam logic [COUNT_W-1:0] ACTIVE_TRACKS_RST = 3'd1;
  localparam logic [GAIN_W-1:0]  FADE_OUT_STEP_RST = 17'd3277;
  localparam logic [GAIN_W-1:0]  FADE_IN_STEP_RST  = 17'd655;

  typedef enum logic [1:0] {
    PH_IDLE     = 2'd0,
    PH_FADE_OUT = 2'd1,
    PH_HOLD     = 2'd2,
    PH_FADE_IN  = 2'd3
  } phase_t;

  typedef enum logic [2:0] {
    LOP_KEEP     = 3'd0,
    LOP_FADE_OUT = 3'd1,
    LOP_RELEASE  = 3'd2,
    LOP_UNITY    = 3'd3,
    LOP_FADE_IN  = 3'd4
  } lane_op_t;

  typedef struct packed {
    lane_op_t          op;
    logic [GAIN_W-1:0] fi_gain;
  } lane_cmd_t;

  typedef struct packed {
    logic              keep_playing;
    logic              paused;
    logic              pause_cmd;
    logic              play_cmd;
    logic [GAIN_W-1:0] gain_next;
  } lane_stat_t;

  typedef struct packed {
    logic       jingle_playing;
    logic [1:0] track0_play_state;
    logic [1:0] track1_play_state;
    logic [1:0] track2_play_state;
    logic [1:0] track3_play_state;
    logic [3:0] no_resume_mask;
  } in_item_t;

  typedef struct packed {
    logic [1:0]        watch_phase;
    logic              music_held;
    logic [3:0]        pause_command_mask;
    logic [3:0]        play_command_mask;
    logic [GAIN_W-1:0] gain_track0;
    logic [GAIN_W-1:0] gain_track1;
    logic [GAIN_W-1:0] gain_track2;
    logic [GAIN_W-1:0] gain_track3;
  } out_item_t;

endpackage

// ===== rtl/core/music_ducking_fade_controller.sv =====
// ----------------------------------------------------------------------------
// music_ducking_fade_controller
// Ducks the music tracks around a jingle: fade out, hold, fade back in.
// ----------------------------------------------------------------------------
// Output: the result of an item is in the output register on the cycle after
//   the item is accepted.
// Throughput: 1 item per cycle; all four track lanes and the phase machine
//   update on the same edge. A waiting result blocks the input; the next
//   item goes in on the same edge that the waiting result is taken.
// Reset (rst, synchronous): phase idle, not held, all gains unity, config at
//   1 track, fade-out step 3277, fade-in step 655, output empty.
// ----------------------------------------------------------------------------
module music_ducking_fade_controller (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  mdfc_pkg::in_item_t              in_item,
  output logic                            out_valid,
  input  logic                            out_ready,
  output mdfc_pkg::out_item_t             out_item,
  input  logic                            cfg_we,
  input  logic [mdfc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mdfc_pkg::GAIN_W-1:0]     cfg_data
);
  import mdfc_pkg::*;

  // configuration
  logic [COUNT_W-1:0] active_tracks;
  logic [GAIN_W-1:0]  fade_out_step;
  logic [GAIN_W-1:0]  fade_in_step;

  // handshake
  logic take;

  // lanes and merge
  logic [1:0]            st    [MAX_TRACKS];
  logic [GAIN_W-1:0]     gain  [MAX_TRACKS];
  lane_stat_t            stat  [MAX_TRACKS];
  lane_cmd_t             cmd;
  logic [MAX_TRACKS-1:0] active;
  phase_t                phase_next;
  logic                  held_next;
  logic [MAX_TRACKS-1:0] pause_mask;
  logic [MAX_TRACKS-1:0] play_mask;
  out_item_t             result;

  // user makes config writes only while idle; no interlock enforces it
  always_ff @(posedge clk) begin
    if (rst) begin
      active_tracks <= ACTIVE_TRACKS_RST;
      fade_out_step <= FADE_OUT_STEP_RST;
      fade_in_step  <= FADE_IN_STEP_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ACTIVE_TRACKS: active_tracks <= cfg_data[COUNT_W-1:0];
        CFG_FADE_OUT_STEP: fade_out_step <= cfg_data;
        CFG_FADE_IN_STEP:  fade_in_step  <= cfg_data;
        default: ;
      endcase
    end
  end

  // take an item whenever the output register is free or being drained
  assign in_ready = !out_valid || out_ready;
  assign take     = in_valid && in_ready;

  assign st[0] = in_item.track0_play_state;
  assign st[1] = in_item.track1_play_state;
  assign st[2] = in_item.track2_play_state;
  assign st[3] = in_item.track3_play_state;

  // one lane per track; each owns its gain
  for (genvar i = 0; i < MAX_TRACKS; i++) begin : g_lane
    mdfc_lane u_lane (
      .clk           (clk),
      .rst           (rst),
      .take          (take),
      .active        (active[i]),
      .cmd           (cmd),
      .fade_out_step (fade_out_step),
      .play_state    (st[i]),
      .no_resume     (in_item.no_resume_mask[i]),
      .gain          (gain[i]),
      .stat          (stat[i])
    );
  end

  // phase machine; fade-in is led by track 0, release by the last track
  mdfc_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .take          (take),
    .jingle        (in_item.jingle_playing),
    .st0           (st[0]),
    .active_tracks (active_tracks),
    .fade_in_step  (fade_in_step),
    .gain0         (gain[0]),
    .stat          (stat),
    .cmd           (cmd),
    .active        (active),
    .phase_next    (phase_next),
    .held_next     (held_next)
  );

  always_comb begin
    for (int i = 0; i < MAX_TRACKS; i++) begin
      pause_mask[i] = stat[i].pause_cmd;
      play_mask[i]  = stat[i].play_cmd;
    end
  end

  // result carries the state after the update
  always_comb begin
    result.watch_phase        = phase_next;
    result.music_held         = held_next;
    result.pause_command_mask = pause_mask;
    result.play_command_mask  = play_mask;
    result.gain_track0        = stat[0].gain_next;
    result.gain_track1        = stat[1].gain_next;
    result.gain_track2        = stat[2].gain_next;
    result.gain_track3        = stat[3].gain_next;
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_item <= result;
    end
  end

  // pause commands only come in fade-out, play commands only on release
  a_cmd_excl: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !((|out_item.pause_command_mask) && (|out_item.play_command_mask)))
    else $error("pause and play commanded on the same item");

  // gains never exceed unity
  a_gain_max: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_item.gain_track0 <= GAIN_UNITY && out_item.gain_track1 <= GAIN_UNITY
                && out_item.gain_track2 <= GAIN_UNITY && out_item.gain_track3 <= GAIN_UNITY))
    else $error("gain above unity");

  // an item taken always yields a result next cycle
  a_take_result: assert property (@(posedge clk) disable iff (rst)
    take |=> out_valid)
    else $error("accepted item lost");

endmodule

// ===== rtl/core/mdfc_lane.sv =====
// ----------------------------------------------------------------------------
// mdfc_lane
// One track: holds its gain and works out its gain step and commands.
// ----------------------------------------------------------------------------
module mdfc_lane (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      take,
  input  logic                      active,
  input  mdfc_pkg::lane_cmd_t       cmd,
  input  logic [mdfc_pkg::GAIN_W-1:0] fade_out_step,
  input  logic [1:0]                play_state,
  input  logic                      no_resume,
  output logic [mdfc_pkg::GAIN_W-1:0] gain,
  output mdfc_pkg::lane_stat_t      stat
);
  import mdfc_pkg::*;

  logic keep;
  logic paused;

  // still playing after a fade-out step
  assign keep   = (play_state == ST_PLAYING) && (gain >= fade_out_step);
  assign paused = (play_state == ST_PAUSED);

  always_comb begin
    stat.keep_playing = keep;
    stat.paused       = paused;
    stat.pause_cmd    = 1'b0;
    stat.play_cmd     = 1'b0;
    stat.gain_next    = gain;
    if (active) begin
      case (cmd.op)
        LOP_FADE_OUT: begin
          if (keep) begin
            stat.gain_next = gain - fade_out_step;
          end else begin
            stat.gain_next = '0;
            stat.pause_cmd = 1'b1;
          end
        end
        LOP_RELEASE: begin
          if (paused) begin
            stat.play_cmd = 1'b1;
          end else begin
            stat.gain_next = GAIN_UNITY;
            stat.play_cmd  = !no_resume;
          end
        end
        LOP_UNITY:   stat.gain_next = GAIN_UNITY;
        LOP_FADE_IN: stat.gain_next = cmd.fi_gain;
        default:     stat.gain_next = gain;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      gain <= GAIN_UNITY;
    end else if (take) begin
      gain <= stat.gain_next;
    end
  end

endmodule

// ===== rtl/core/mdfc_ctrl.sv =====
// ----------------------------------------------------------------------------
// mdfc_ctrl
// Ducking phase machine: drives the lanes and merges their findings.
// ----------------------------------------------------------------------------
module mdfc_ctrl (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          take,
  input  logic                          jingle,
  input  logic [1:0]                    st0,
  input  logic [mdfc_pkg::COUNT_W-1:0]  active_tracks,
  input  logic [mdfc_pkg::GAIN_W-1:0]   fade_in_step,
  input  logic [mdfc_pkg::GAIN_W-1:0]   gain0,
  input  mdfc_pkg::lane_stat_t          stat [mdfc_pkg::MAX_TRACKS],
  output mdfc_pkg::lane_cmd_t           cmd,
  output logic [mdfc_pkg::MAX_TRACKS-1:0] active,
  output mdfc_pkg::phase_t              phase_next,
  output logic                          held_next
);
  import mdfc_pkg::*;

  phase_t             phase;
  logic               held;
  logic [COUNT_W-1:0] n;
  logic [TRK_W-1:0]   last_idx;
  logic               any_keep;
  logic [GAIN_W:0]    fi_sum;
  logic               fi_full;

  // 0 acts as 1, anything above the lane count as the lane count
  always_comb begin
    if (active_tracks == '0) begin
      n = COUNT_W'(1);
    end else if (active_tracks > COUNT_W'(MAX_TRACKS)) begin
      n = COUNT_W'(MAX_TRACKS);
    end else begin
      n = active_tracks;
    end
  end

  assign last_idx = TRK_W'(n - COUNT_W'(1));

  always_comb begin
    any_keep = 1'b0;
    for (int i = 0; i < MAX_TRACKS; i++) begin
      active[i] = (COUNT_W'(i) < n);
      any_keep  = any_keep | (active[i] & stat[i].keep_playing);
    end
  end

  assign fi_sum  = {1'b0, gain0} + {1'b0, fade_in_step};
  assign fi_full = (fi_sum >= {1'b0, GAIN_UNITY});

  // next state
  always_comb begin
    phase_next = phase;
    case (phase)
      PH_IDLE: begin
        if (jingle) phase_next = PH_FADE_OUT;
      end
      PH_FADE_OUT: begin
        if (!jingle) begin
          phase_next = PH_FADE_IN;
        end else if (!any_keep) begin
          phase_next = PH_HOLD;
        end
      end
      PH_HOLD: begin
        if (!jingle) begin
          phase_next = stat[last_idx].paused ? PH_FADE_IN : PH_IDLE;
        end
      end
      PH_FADE_IN: begin
        if (st0 == ST_STOPPED) begin
          phase_next = PH_IDLE;
        end else if (jingle) begin
          phase_next = PH_FADE_OUT;
        end else if (fi_full) begin
          phase_next = PH_IDLE;
        end
      end
      default: phase_next = PH_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd.op      = LOP_KEEP;
    cmd.fi_gain = fi_full ? GAIN_UNITY : fi_sum[GAIN_W-1:0];
    held_next   = held;
    case (phase)
      PH_IDLE: begin
        if (jingle) held_next = 1'b1;
      end
      PH_FADE_OUT: begin
        if (jingle) cmd.op = LOP_FADE_OUT;
      end
      PH_HOLD: begin
        if (!jingle) begin
          cmd.op    = LOP_RELEASE;
          held_next = 1'b0;
        end
      end
      PH_FADE_IN: begin
        if (st0 == ST_STOPPED) begin
          cmd.op = LOP_UNITY;
        end else if (jingle) begin
          held_next = 1'b1;
        end else begin
          cmd.op = LOP_FADE_IN;
        end
      end
      default: cmd.op = LOP_KEEP;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      held  <= 1'b0;
    end else if (take) begin
      phase <= phase_next;
      held  <= held_next;
    end
  end

  // music stays held through fade-out and hold
  a_held_in_duck: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_FADE_OUT || phase == PH_HOLD) |-> held)
    else $error("held flag clear while ducking");

  // idle with no jingle stays idle
  a_idle_stays: assert property (@(posedge clk) disable iff (rst)
    (take && phase == PH_IDLE && !jingle) |=> (phase == PH_IDLE))
    else $error("left idle without a jingle");

endmodule
